// ===== rtl/pls_pkg.sv =====
package pls_pkg;

   // Field widths of the item formats
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int FIELD_W  = 16;
   localparam int ENTRY_W  = 7;
   localparam int R2_W     = 2 * FIELD_W;

   // Request operation codes (codes six and seven act as no-ops)
   typedef enum logic [OP_W-1:0] {
      OP_INSERT       = 3'd0,
      OP_REMOVE_FRONT = 3'd1,
      OP_REMOVE_MATCH = 3'd2,
      OP_RADIUS       = 3'd3,
      OP_MEMBER       = 3'd4,
      OP_COUNT        = 3'd5
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EMIT,
      S_FIND,
      S_SHIFT,
      S_RADIUS
   } state_type;

endpackage

// ===== rtl/point_list_store_top.sv =====
// Ordered point list, newest first, held in one point memory.
// Request channel (req_*): one item per operation; tuser carries the op code,
// tdata the point and radius. Response channel (rsp_*): tuser carries status,
// tdata the point and the entry count, tlast marks the final item of a request.
// Every request gives one response item, except a radius query with hits,
// which gives one item per hit in list order.
// Timing: a request is taken only while the controller is idle.
//   insert, remove front, count, no-op: the emit state loads the item.
//   member / remove match: one memory read per entry, newest first. Remove
//   match then moves the newer entries down one slot each, one read and one
//   write per cycle. The emit state then loads the response item.
//   radius query: one entry per cycle through read, square and compare
//   stages, while the receiver takes the response items.
// The next request is taken in the cycle after the final response item
// is loaded. A stalled receiver holds the response register; the radius
// scan freezes until the item is taken, and a request taken meanwhile
// waits in its last step.
// Reset empties the list; memory contents are not cleared.
module point_list_store_top #(
   parameter int DEPTH      = 64,
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // coord_x[15:0], coord_y[31:16], radius[47:32]
   input  logic [2:0]  req_tuser,   // op[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // point_x[15:0], point_y[31:16], entries[38:32], zero
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);

   localparam int CB     = COORD_BITS;
   localparam int PT_W   = 2 * CB;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SQ_W   = 2 * CB;
   localparam int CMP_W  = (SQ_W + 1 > pls_pkg::R2_W) ? SQ_W + 1 : pls_pkg::R2_W;
   localparam int FW     = pls_pkg::FIELD_W;

   // Control registers
   pls_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                is_remove_ff, is_remove_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s2_valid_ff, s2_valid_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [PT_W-1:0]        pt_ff, pt_in;
   logic [pls_pkg::R2_W-1:0] r2_ff, r2_in;
   logic [ADDR_W-1:0]      s1_idx_ff, s1_idx_in;
   logic [PT_W-1:0]        s2_pt_ff, s2_pt_in;
   logic [SQ_W-1:0]        sqx_ff, sqx_in;
   logic [SQ_W-1:0]        sqy_ff, sqy_in;
   logic [PT_W-1:0]        pend_pt_ff, pend_pt_in;
   pls_pkg::status_type    emit_status_ff, emit_status_in;
   pls_pkg::status_type    rsp_status_ff;
   logic [FW-1:0]          rsp_x_ff, rsp_y_ff;
   logic                   rsp_last_ff;
   logic [pls_pkg::ENTRY_W-1:0] rsp_entries_ff;

   // Point memory, {y, x} per entry, physical 0 is the oldest point
   logic [PT_W-1:0]   mem_ram [DEPTH];
   logic [PT_W-1:0]   rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [PT_W-1:0]   mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   // Response load
   logic                out_load;
   pls_pkg::status_type out_status;
   logic [PT_W-1:0]     out_pt;
   logic                out_last;

   // Request decode
   logic [FW-1:0]     req_x, req_y, req_r;
   logic [PT_W-1:0]   req_pt;
   logic              req_accept;
   logic              out_free;

   // Radius datapath
   logic [CB-1:0]     rd_x, rd_y, mag_x, mag_y;
   logic              in_radius;

   assign req_x      = req_tdata[15:0];
   assign req_y      = req_tdata[31:16];
   assign req_r      = req_tdata[47:32];
   assign req_pt     = {CB'(req_y), CB'(req_x)};
   assign req_tready = (state_ff == pls_pkg::S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rd_x  = rd_data_ff[CB-1:0];
   assign rd_y  = rd_data_ff[PT_W-1:CB];
   assign mag_x = rd_x[CB-1] ? (~rd_x + CB'(1)) : rd_x;
   assign mag_y = rd_y[CB-1] ? (~rd_y + CB'(1)) : rd_y;
   assign in_radius = (CMP_W'(sqx_ff) + CMP_W'(sqy_ff)) <= CMP_W'(r2_ff);

   // Next state and datapath control
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      is_remove_in   = is_remove_ff;
      addr_in        = addr_ff;
      left_in        = left_ff;
      s1_valid_in    = s1_valid_ff;
      s2_valid_in    = s2_valid_ff;
      pend_valid_in  = pend_valid_ff;
      pt_in          = pt_ff;
      r2_in          = r2_ff;
      s1_idx_in      = s1_idx_ff;
      s2_pt_in       = s2_pt_ff;
      sqx_in         = sqx_ff;
      sqy_in         = sqy_ff;
      pend_pt_in     = pend_pt_ff;
      emit_status_in = emit_status_ff;
      mem_we         = 1'b0;
      mem_waddr      = ADDR_W'(count_ff);
      mem_wdata      = req_pt;
      mem_re         = 1'b0;
      mem_raddr      = addr_ff;
      out_load       = 1'b0;
      out_status     = pls_pkg::ST_OK;
      out_pt         = '0;
      out_last       = 1'b1;

      case (state_ff)
         pls_pkg::S_IDLE: begin
            if (req_accept) begin
               pt_in          = req_pt;
               emit_status_in = pls_pkg::ST_OK;
               state_in       = pls_pkg::S_EMIT;
               case (req_tuser)
                  pls_pkg::OP_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        emit_status_in = pls_pkg::ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  pls_pkg::OP_REMOVE_FRONT: begin
                     if (count_ff == '0) begin
                        emit_status_in = pls_pkg::ST_MISS;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  pls_pkg::OP_REMOVE_MATCH, pls_pkg::OP_MEMBER: begin
                     is_remove_in = (req_tuser == pls_pkg::OP_REMOVE_MATCH);
                     addr_in      = ADDR_W'(count_ff - CNT_W'(1));
                     left_in      = count_ff;
                     s1_valid_in  = 1'b0;
                     state_in     = pls_pkg::S_FIND;
                  end
                  pls_pkg::OP_RADIUS: begin
                     r2_in         = pls_pkg::R2_W'(req_r) * pls_pkg::R2_W'(req_r);
                     addr_in       = ADDR_W'(count_ff - CNT_W'(1));
                     left_in       = count_ff;
                     s1_valid_in   = 1'b0;
                     s2_valid_in   = 1'b0;
                     pend_valid_in = 1'b0;
                     state_in      = pls_pkg::S_RADIUS;
                  end
                  default: begin
                     emit_status_in = pls_pkg::ST_OK;
                  end
               endcase
            end
         end

         // Single response item
         pls_pkg::S_EMIT: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_status = emit_status_ff;
               state_in   = pls_pkg::S_IDLE;
            end
         end

         // Linear search in list order (newest first), one entry per cycle
         pls_pkg::S_FIND: begin
            if (left_ff != '0) begin
               mem_re    = 1'b1;
               addr_in   = addr_ff - ADDR_W'(1);
               left_in   = left_ff - CNT_W'(1);
               s1_idx_in = addr_ff;
            end
            s1_valid_in = (left_ff != '0);
            if (s1_valid_ff && rd_data_ff == pt_ff) begin
               s1_valid_in = 1'b0;
               if (is_remove_ff) begin
                  addr_in  = s1_idx_ff + ADDR_W'(1);
                  left_in  = count_ff - CNT_W'(1) - CNT_W'(s1_idx_ff);
                  state_in = pls_pkg::S_SHIFT;
               end else begin
                  emit_status_in = pls_pkg::ST_OK;
                  state_in       = pls_pkg::S_EMIT;
               end
            end else if (left_ff == '0 && !s1_valid_ff) begin
               emit_status_in = pls_pkg::ST_MISS;
               state_in       = pls_pkg::S_EMIT;
            end
         end

         // Close the gap: entry i+1 moves to i
         pls_pkg::S_SHIFT: begin
            if (left_ff != '0) begin
               mem_re    = 1'b1;
               addr_in   = addr_ff + ADDR_W'(1);
               left_in   = left_ff - CNT_W'(1);
               s1_idx_in = addr_ff;
            end
            s1_valid_in = (left_ff != '0);
            if (s1_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = s1_idx_ff - ADDR_W'(1);
               mem_wdata = rd_data_ff;
            end
            if (left_ff == '0 && !s1_valid_ff) begin
               count_in       = count_ff - CNT_W'(1);
               emit_status_in = pls_pkg::ST_OK;
               state_in       = pls_pkg::S_EMIT;
            end
         end

         // Read, square, compare; one hit held back to mark the last item
         pls_pkg::S_RADIUS: begin
            if (out_free) begin
               if (left_ff != '0) begin
                  mem_re  = 1'b1;
                  addr_in = addr_ff - ADDR_W'(1);
                  left_in = left_ff - CNT_W'(1);
               end
               s1_valid_in = (left_ff != '0);
               s2_valid_in = s1_valid_ff;
               s2_pt_in    = rd_data_ff;
               sqx_in      = SQ_W'(mag_x) * SQ_W'(mag_x);
               sqy_in      = SQ_W'(mag_y) * SQ_W'(mag_y);
               if (s2_valid_ff && in_radius) begin
                  if (pend_valid_ff) begin
                     out_load = 1'b1;
                     out_pt   = pend_pt_ff;
                     out_last = 1'b0;
                  end
                  pend_pt_in    = s2_pt_ff;
                  pend_valid_in = 1'b1;
               end else if (left_ff == '0 && !s1_valid_ff && !s2_valid_ff) begin
                  out_load      = 1'b1;
                  out_status    = pend_valid_ff ? pls_pkg::ST_OK : pls_pkg::ST_MISS;
                  out_pt        = pend_valid_ff ? pend_pt_ff : '0;
                  pend_valid_in = 1'b0;
                  state_in      = pls_pkg::S_IDLE;
               end
            end
         end

         default: begin
            state_in = pls_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pls_pkg::S_IDLE;
         count_ff      <= '0;
         is_remove_ff  <= 1'b0;
         addr_ff       <= '0;
         left_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         is_remove_ff  <= is_remove_in;
         addr_ff       <= addr_in;
         left_ff       <= left_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      pt_ff          <= pt_in;
      r2_ff          <= r2_in;
      s1_idx_ff      <= s1_idx_in;
      s2_pt_ff       <= s2_pt_in;
      sqx_ff         <= sqx_in;
      sqy_ff         <= sqy_in;
      pend_pt_ff     <= pend_pt_in;
      emit_status_ff <= emit_status_in;
      if (out_load) begin
         rsp_status_ff  <= out_status;
         rsp_x_ff       <= FW'($signed(out_pt[CB-1:0]));
         rsp_y_ff       <= FW'($signed(out_pt[PT_W-1:CB]));
         rsp_last_ff    <= out_last;
         rsp_entries_ff <= pls_pkg::ENTRY_W'(count_ff);
      end
   end

   // Point memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ram[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_entries_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sim/tb_point_list_store_top.sv =====
`timescale 1ns / 100ps

module tb_point_list_store_top;

   localparam int DEPTH       = 64;
   localparam int ITEM_TARGET = 410;
   localparam int CYCLE_LIMIT = 2_000_000;

   // Op codes past OP_COUNT, which the block treats as no-ops
   localparam logic [pls_pkg::OP_W-1:0] OP_NOP_LO = 3'd6;
   localparam logic [pls_pkg::OP_W-1:0] OP_NOP_HI = 3'd7;

   typedef enum {CM_FULL, CM_SMALL, CM_EXTREME} coord_mode_type;
   typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} ready_pattern_type;

   // One response item, field by field
   typedef struct {
      pls_pkg::status_type status;
      logic signed [15:0]  point_x;
      logic signed [15:0]  point_y;
      logic                last;
      logic [6:0]          entries;
   } rsp_fields_type;

   // Shadow copy of the point list plus the queue of responses it implies
   class point_list_tracker;
      logic signed [15:0] pt_x[$];
      logic signed [15:0] pt_y[$];
      rsp_fields_type     pending_rsp[$];
      int errors, requests, responses, radius_hits, full_drops, misses, peak_fill;

      function longint unsigned sq_dist(logic signed [15:0] x, logic signed [15:0] y);
         longint ax;
         longint ay;
         ax = x;
         ay = y;
         if (ax < 0) ax = -ax;
         if (ay < 0) ay = -ay;
         return longint'(ax * ax + ay * ay);
      endfunction

      function int find_point(logic signed [15:0] x, logic signed [15:0] y);
         for (int i = 0; i < pt_x.size(); i++)
            if (pt_x[i] == x && pt_y[i] == y) return i;
         return -1;
      endfunction

      function void note_request(logic [pls_pkg::OP_W-1:0] op, logic signed [15:0] x,
                                 logic signed [15:0] y, logic [15:0] r);
         rsp_fields_type    res;
         rsp_fields_type    hit;
         int                idx;
         int                hits_here;
         longint unsigned   r_wide;
         longint unsigned   lim;
         requests++;
         res.status  = pls_pkg::ST_OK;
         res.point_x = '0;
         res.point_y = '0;
         res.last    = 1'b1;
         hits_here   = 0;
         case (op)
            pls_pkg::OP_INSERT: begin
               if (pt_x.size() >= DEPTH) begin
                  res.status = pls_pkg::ST_FULL;
                  full_drops++;
               end else begin
                  pt_x.push_front(x);
                  pt_y.push_front(y);
               end
            end
            pls_pkg::OP_REMOVE_FRONT: begin
               if (pt_x.size() == 0) begin
                  res.status = pls_pkg::ST_MISS;
               end else begin
                  void'(pt_x.pop_front());
                  void'(pt_y.pop_front());
               end
            end
            pls_pkg::OP_REMOVE_MATCH: begin
               idx = find_point(x, y);
               if (idx < 0) begin
                  res.status = pls_pkg::ST_MISS;
               end else begin
                  pt_x.delete(idx);
                  pt_y.delete(idx);
               end
            end
            pls_pkg::OP_RADIUS: begin
               r_wide = r;
               lim    = r_wide * r_wide;
               for (int i = 0; i < pt_x.size(); i++) begin
                  if (sq_dist(pt_x[i], pt_y[i]) <= lim) begin
                     hit.status  = pls_pkg::ST_OK;
                     hit.point_x = pt_x[i];
                     hit.point_y = pt_y[i];
                     hit.last    = 1'b0;
                     hit.entries = 7'(pt_x.size());
                     pending_rsp.push_back(hit);
                     hits_here++;
                  end
               end
               // tag the final hit of this query
               if (hits_here != 0) begin
                  hit      = pending_rsp.pop_back();
                  hit.last = 1'b1;
                  pending_rsp.push_back(hit);
                  radius_hits += hits_here;
               end else begin
                  res.status = pls_pkg::ST_MISS;
               end
            end
            pls_pkg::OP_MEMBER: begin
               if (find_point(x, y) < 0) res.status = pls_pkg::ST_MISS;
            end
            default: ;
         endcase
         if (res.status == pls_pkg::ST_MISS) misses++;
         if (pt_x.size() > peak_fill) peak_fill = pt_x.size();
         res.entries = 7'(pt_x.size());
         if (op != pls_pkg::OP_RADIUS || hits_here == 0) pending_rsp.push_back(res);
      endfunction

      function void check_response(rsp_fields_type got);
         rsp_fields_type want;
         responses++;
         if (pending_rsp.size() == 0) begin
            errors++;
            $error("response item with nothing pending: status %0d x %0d y %0d",
                   got.status, got.point_x, got.point_y);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.status !== want.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", want.status, got.status);
         end
         if (got.point_x !== want.point_x) begin
            errors++;
            $error("point_x: expected %0d, actual %0d", want.point_x, got.point_x);
         end
         if (got.point_y !== want.point_y) begin
            errors++;
            $error("point_y: expected %0d, actual %0d", want.point_y, got.point_y);
         end
         if (got.last !== want.last) begin
            errors++;
            $error("last: expected %0d, actual %0d", want.last, got.last);
         end
         if (got.entries !== want.entries) begin
            errors++;
            $error("entries: expected %0d, actual %0d", want.entries, got.entries);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // coord_x[15:0], coord_y[31:16], radius[47:32]
   logic [2:0]  req_tuser  = '0;   // op[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // point_x[15:0], point_y[31:16], entries[38:32], zero
   logic [1:0]  rsp_tuser;         // status[1:0]
   logic        rsp_tlast;

   point_list_tracker store_sb = new();
   int items_sent  = 0;
   int burst_left  = 0;
   int cycle_count = 0;

   point_list_store_top #(
      .DEPTH      (DEPTH),
      .COORD_BITS (16)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items still pending",
                  cycle_count, store_sb.pending_rsp.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Watch both channels; requests are noted before responses are checked
   always @(posedge clock) begin
      rsp_fields_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            store_sb.note_request(req_tuser, req_tdata[15:0], req_tdata[31:16],
                                  req_tdata[47:32]);
         if (rsp_tvalid && rsp_tready) begin
            got.status  = pls_pkg::status_type'(rsp_tuser);
            got.point_x = rsp_tdata[15:0];
            got.point_y = rsp_tdata[31:16];
            got.entries = rsp_tdata[38:32];
            got.last    = rsp_tlast;
            store_sb.check_response(got);
         end
      end
   end

   // Receiver back-pressure: switches at random between four ready patterns
   ready_pattern_type ready_mode = RDY_ALWAYS;
   int ready_mode_left = 0;
   int ready_phase     = 0;
   always @(posedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode      = ready_pattern_type'($urandom_range(3));
         ready_mode_left = $urandom_range(300, 40);
      end
      ready_mode_left--;
      ready_phase = (ready_phase + 1) % 7;
      case (ready_mode)
         RDY_ALWAYS: rsp_tready <= 1'b1;
         RDY_MOSTLY: rsp_tready <= ($urandom_range(3) != 0);
         RDY_RARELY: rsp_tready <= ($urandom_range(3) == 0);
         default:    rsp_tready <= (ready_phase < 2);
      endcase
   end

   function automatic logic signed [15:0] rand_coord(coord_mode_type cm);
      case (cm)
         CM_SMALL: return 16'(int'($urandom_range(6)) - 3);
         CM_EXTREME: begin
            case ($urandom_range(4))
               0:       return -16'sd32768;
               1:       return 16'sd32767;
               2:       return 16'sd0;
               3:       return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   // Radius: random, tiny, extreme, or around a stored point's distance
   function automatic logic [15:0] rand_radius();
      int  idx;
      int  r;
      real d;
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(20));
         2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: begin
            if (store_sb.pt_x.size() == 0) return 16'($urandom);
            idx = $urandom_range(store_sb.pt_x.size() - 1);
            d   = $sqrt(real'(store_sb.sq_dist(store_sb.pt_x[idx], store_sb.pt_y[idx])));
            r   = int'($floor(d)) + int'($urandom_range(2)) - 1;
            if (r < 0) r = 0;
            if (r > 65535) r = 65535;
            return 16'(r);
         end
      endcase
   endfunction

   // Sender gaps: bursts of random length, short or long
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
         gap        = $urandom_range(12, 1);
         req_tvalid <= 1'b0;
         req_tdata  <= {16'($urandom), 32'($urandom)};
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_item(input logic [pls_pkg::OP_W-1:0] op,
                            input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic [15:0] r);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {r, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      pace_sender();
   endtask

   // Two times in three, when the store is not empty, aim at a point that is actually stored
   task automatic send_pointed(input logic [pls_pkg::OP_W-1:0] op, input coord_mode_type cm);
      int idx;
      if (store_sb.pt_x.size() != 0 && $urandom_range(2) != 0) begin
         idx = $urandom_range(store_sb.pt_x.size() - 1);
         send_item(op, store_sb.pt_x[idx], store_sb.pt_y[idx], 16'($urandom));
      end else begin
         send_item(op, rand_coord(cm), rand_coord(cm), 16'($urandom));
      end
   endtask

   task automatic run_directed();
      // empty store corner cases
      send_item(pls_pkg::OP_COUNT, 16'sd0, 16'sd0, 16'h0000);
      send_item(pls_pkg::OP_REMOVE_FRONT, 16'sd0, 16'sd0, 16'h0000);
      send_item(pls_pkg::OP_REMOVE_MATCH, 16'sd0, 16'sd0, 16'h0000);
      send_item(pls_pkg::OP_MEMBER, 16'sd0, 16'sd0, 16'h0000);
      send_item(pls_pkg::OP_RADIUS, 16'sd0, 16'sd0, 16'hFFFF);
      // extremes, origin and a duplicate
      send_item(pls_pkg::OP_INSERT, -16'sd32768, -16'sd32768, 16'hFFFF);
      send_item(pls_pkg::OP_INSERT, 16'sd32767, 16'sd32767, 16'h0000);
      send_item(pls_pkg::OP_INSERT, 16'sd0, 16'sd0, 16'h0000);
      send_item(pls_pkg::OP_INSERT, -16'sd1, 16'sd1, 16'h0000);
      send_item(pls_pkg::OP_INSERT, 16'sd0, 16'sd0, 16'hFFFF);
      send_item(pls_pkg::OP_MEMBER, 16'sd32767, 16'sd32767, 16'h0000);
      send_item(pls_pkg::OP_MEMBER, 16'sd32767, -16'sd32768, 16'h0000);
      // zero radius, full radius, and just inside/outside the corner points
      send_item(pls_pkg::OP_RADIUS, 16'sd0, 16'sd0, 16'h0000);
      send_item(pls_pkg::OP_RADIUS, 16'sd0, 16'sd0, 16'hFFFF);
      send_item(pls_pkg::OP_RADIUS, 16'sd0, 16'sd0, 16'd46340);
      send_item(pls_pkg::OP_RADIUS, 16'sd0, 16'sd0, 16'd1);
      // remove match takes the first of two equal points
      send_item(pls_pkg::OP_REMOVE_MATCH, 16'sd0, 16'sd0, 16'h0000);
      send_item(pls_pkg::OP_RADIUS, 16'sd0, 16'sd0, 16'hFFFF);
      send_item(pls_pkg::OP_REMOVE_MATCH, 16'sd5, 16'sd5, 16'h0000);
      send_item(OP_NOP_LO, 16'sd0, 16'sd0, 16'h0000);
      send_item(OP_NOP_HI, -16'sd1, -16'sd1, 16'hFFFF);
      send_item(pls_pkg::OP_REMOVE_FRONT, 16'sd0, 16'sd0, 16'h0000);
      send_item(pls_pkg::OP_COUNT, 16'sd0, 16'sd0, 16'h0000);
      send_item(pls_pkg::OP_MEMBER, 16'sd0, 16'sd0, 16'h0000);
   endtask

   task automatic run_random();
      coord_mode_type cm;
      int             pick;
      int             n;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(9);
         cm   = coord_mode_type'($urandom_range(2));
         if (pick < 2) begin
            // fill to the top and overflow by a few
            n = DEPTH - store_sb.pt_x.size() + $urandom_range(3, 1);
            repeat (n) send_item(pls_pkg::OP_INSERT, rand_coord(cm), rand_coord(cm),
                                 16'($urandom));
         end else if (pick < 4) begin
            repeat ($urandom_range(10, 4))
               send_item(pls_pkg::OP_RADIUS, rand_coord(cm), rand_coord(cm), rand_radius());
         end else if (pick == 4) begin
            // one removal per stored point, then one more removal
            n = store_sb.pt_x.size() + 1;
            repeat (n) begin
               if ($urandom_range(1)) send_pointed(pls_pkg::OP_REMOVE_MATCH, cm);
               else send_item(pls_pkg::OP_REMOVE_FRONT, rand_coord(cm), rand_coord(cm),
                              16'($urandom));
            end
         end else begin
            repeat ($urandom_range(30, 8)) begin
               pick = $urandom_range(99);
               if (pick < 30)
                  send_item(pls_pkg::OP_INSERT, rand_coord(cm), rand_coord(cm),
                            16'($urandom));
               else if (pick < 40)
                  send_item(pls_pkg::OP_REMOVE_FRONT, rand_coord(cm), rand_coord(cm),
                            16'($urandom));
               else if (pick < 55)
                  send_pointed(pls_pkg::OP_REMOVE_MATCH, cm);
               else if (pick < 70)
                  send_item(pls_pkg::OP_RADIUS, rand_coord(cm), rand_coord(cm),
                            rand_radius());
               else if (pick < 85)
                  send_pointed(pls_pkg::OP_MEMBER, cm);
               else if (pick < 94)
                  send_item(pls_pkg::OP_COUNT, rand_coord(cm), rand_coord(cm),
                            16'($urandom));
               else
                  send_item(pick[0] ? OP_NOP_HI : OP_NOP_LO, rand_coord(cm), rand_coord(cm),
                            16'($urandom));
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (store_sb.pending_rsp.size() != 0) @(posedge clock);
      // let any stray response surface
      repeat (2 * DEPTH + 8) @(posedge clock);
      if (store_sb.pending_rsp.size() != 0) begin
         store_sb.errors++;
         $error("%0d expected response items never arrived", store_sb.pending_rsp.size());
      end
      $display("run covered %0d requests and %0d response items: %0d radius hits,",
               store_sb.requests, store_sb.responses, store_sb.radius_hits);
      $display("  %0d misses, %0d inserts dropped on a full store, peak fill %0d of %0d",
               store_sb.misses, store_sb.full_drops, store_sb.peak_fill, DEPTH);
      if (store_sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
